// File: rtl/jfhs_pkg.sv
// ----------------------------------------------------------------------------
// jfhs_pkg
// Shared types and constants for the JPEG frame header scanner.
// ----------------------------------------------------------------------------
package jfhs_pkg;

  // Marker and field values
  localparam logic [7:0] PadByte     = 8'hFF;
  localparam logic [7:0] SoiCode     = 8'hD8;
  localparam logic [7:0] SofMinCode  = 8'hC0;
  localparam logic [7:0] SofMaxCode  = 8'hC2;
  localparam logic [15:0] SofLenMin  = 16'd11;
  localparam logic [7:0] PrecisionReq = 8'd8;
  localparam logic [15:0] MinSegLen  = 16'd2;

  // Accepted component counts
  localparam logic [7:0] CompsGray  = 8'd1;
  localparam logic [7:0] CompsColor = 8'd3;
  localparam logic [7:0] CompsCmyk  = 8'd4;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_SOI_MISSING    = 3'd1,
    ST_SOF_MISSING    = 3'd2,
    ST_TRUNCATED      = 3'd3,
    ST_SOF_SHORT      = 3'd4,
    ST_BAD_PRECISION  = 3'd5,
    ST_ZERO_SIZE      = 3'd6,
    ST_BAD_COMPONENTS = 3'd7
  } status_e;

  // One scan result
  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [15:0] width;
    logic [15:0] height;
  } result_t;

endpackage

// File: rtl/jfhs_byte_if.sv
// ----------------------------------------------------------------------------
// jfhs_byte_if
// Byte stream channel: one file byte per transfer, flag on the final byte.
// ----------------------------------------------------------------------------
interface jfhs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/jfhs_result_if.sv
// ----------------------------------------------------------------------------
// jfhs_result_if
// Result channel: status and frame dimensions, one transfer per file.
// ----------------------------------------------------------------------------
interface jfhs_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] width;
  logic [15:0] height;

  modport source (output valid, output status, output width, output height,
                  input ready);
  modport sink   (input valid, input status, input width, input height,
                  output ready);
endinterface

// File: rtl/jfhs_parser.sv
// ----------------------------------------------------------------------------
// jfhs_parser
// Marker scanner state machine; one byte per step, result flagged combinationally.
// ----------------------------------------------------------------------------
module jfhs_parser
  import jfhs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output result_t     res_o
);

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_SOI    = 3'd1,
    PH_SCAN   = 3'd2,
    PH_MARK   = 3'd3,
    PH_LEN_HI = 3'd4,
    PH_LEN_LO = 3'd5,
    PH_SKIP   = 3'd6,
    PH_SOF    = 3'd7
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        drain_q, drain_d;
  logic [15:0] skip_q, skip_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [2:0]  field_q, field_d;
  logic [15:0] sof_len_q, sof_len_d;
  logic [7:0]  prec_q, prec_d;
  logic [15:0] height_q, height_d;
  logic [15:0] width_q, width_d;

  logic [15:0] seg_len;
  logic [15:0] skip_dec;
  logic        chk_end;  // generic end-of-file check on scanning phases
  logic        fin;
  status_e     fin_st;
  logic        ok_out;

  assign seg_len  = {len_hi_q, data_byte_i};
  assign skip_dec = skip_q - 16'd1;

  always_comb begin
    phase_d   = phase_q;
    drain_d   = drain_q;
    skip_d    = skip_q;
    len_hi_d  = len_hi_q;
    field_d   = field_q;
    sof_len_d = sof_len_q;
    prec_d    = prec_q;
    height_d  = height_q;
    width_d   = width_q;
    chk_end   = 1'b0;
    fin       = 1'b0;
    fin_st    = ST_OK;
    ok_out    = 1'b0;

    if (drain_q) begin
      if (last_byte_i) begin
        drain_d = 1'b0;
        phase_d = PH_FIRST;
      end
    end else begin
      unique case (phase_q)
        PH_FIRST: begin
          if (data_byte_i != PadByte || last_byte_i) begin
            fin    = 1'b1;
            fin_st = ST_SOI_MISSING;
          end else begin
            phase_d = PH_SOI;
          end
        end
        PH_SOI: begin
          if (data_byte_i == PadByte) begin
            if (last_byte_i) begin
              fin    = 1'b1;
              fin_st = ST_SOI_MISSING;
            end
          end else if (data_byte_i == SoiCode) begin
            if (last_byte_i) begin
              fin    = 1'b1;
              fin_st = ST_SOF_MISSING;
            end else begin
              phase_d = PH_SCAN;
            end
          end else begin
            fin    = 1'b1;
            fin_st = ST_SOI_MISSING;
          end
        end
        PH_SCAN: begin
          chk_end = 1'b1;
          if (data_byte_i == PadByte) phase_d = PH_MARK;
        end
        PH_MARK: begin
          if (data_byte_i >= SofMinCode && data_byte_i <= SofMaxCode) begin
            if (last_byte_i) begin
              fin    = 1'b1;
              fin_st = ST_TRUNCATED;
            end else begin
              phase_d = PH_SOF;
              field_d = 3'd0;
            end
          end else begin
            chk_end = 1'b1;
            if (data_byte_i != PadByte) phase_d = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          chk_end  = 1'b1;
          len_hi_d = data_byte_i;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (seg_len < MinSegLen) begin
            fin    = 1'b1;
            fin_st = ST_SOF_MISSING;
          end else begin
            chk_end = 1'b1;
            if (seg_len == MinSegLen) begin
              phase_d = PH_SCAN;
            end else begin
              skip_d  = seg_len - MinSegLen;
              phase_d = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          chk_end = 1'b1;
          skip_d  = skip_dec;
          if (skip_dec == 16'd0) phase_d = PH_SCAN;
        end
        PH_SOF: begin
          if (last_byte_i) begin
            fin    = 1'b1;
            fin_st = ST_TRUNCATED;
          end else begin
            field_d = field_q + 3'd1;
            case (field_q)
              3'd0: sof_len_d = {data_byte_i, 8'h00};
              3'd1: sof_len_d = {sof_len_q[15:8], data_byte_i};
              3'd2: prec_d    = data_byte_i;
              3'd3: height_d  = {data_byte_i, 8'h00};
              3'd4: height_d  = {height_q[15:8], data_byte_i};
              3'd5: width_d   = {data_byte_i, 8'h00};
              3'd6: width_d   = {width_q[15:8], data_byte_i};
              default: begin
                // component count byte: run the checks in order
                fin = 1'b1;
                if (sof_len_q < SofLenMin) begin
                  fin_st = ST_SOF_SHORT;
                end else if (prec_q != PrecisionReq) begin
                  fin_st = ST_BAD_PRECISION;
                end else if (width_q == 16'd0 || height_q == 16'd0) begin
                  fin_st = ST_ZERO_SIZE;
                end else if (data_byte_i != CompsGray && data_byte_i != CompsColor &&
                             data_byte_i != CompsCmyk) begin
                  fin_st = ST_BAD_COMPONENTS;
                end else begin
                  fin_st = ST_OK;
                  ok_out = 1'b1;
                end
              end
            endcase
          end
        end
        default: phase_d = PH_FIRST;
      endcase

      if (chk_end && last_byte_i && !fin) begin
        fin    = 1'b1;
        fin_st = ST_SOF_MISSING;
      end

      if (fin) begin
        phase_d = PH_FIRST;
        drain_d = !last_byte_i;
      end
    end
  end

  assign res_o.valid  = fin;
  assign res_o.status = fin_st;
  assign res_o.width  = ok_out ? width_q  : 16'd0;
  assign res_o.height = ok_out ? height_q : 16'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      drain_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      drain_q <= drain_d;
    end
  end

  // Segment and SOF field registers: always written before they are read
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      skip_q    <= skip_d;
      len_hi_q  <= len_hi_d;
      field_q   <= field_d;
      sof_len_q <= sof_len_d;
      prec_q    <= prec_d;
      height_q  <= height_d;
      width_q   <= width_d;
    end
  end

endmodule

// File: rtl/jpeg_frame_header_scanner_top.sv
// ----------------------------------------------------------------------------
// jpeg_frame_header_scanner_top
// Scans a JPEG byte stream for SOI and the first SOF0..SOF2 frame header and
// reports one status with the image dimensions per file.
// ----------------------------------------------------------------------------
//
//   channel     dir  handshake     payload
//   ---------   ---  ------------  -------------------------------------------
//   byte_in_i   in   valid/ready   data_byte[7:0], last_byte
//   result_o    out  valid/ready   status[2:0], width[15:0], height[15:0]
//
// Throughput is one byte per cycle unless a result waits on a busy output
// register: each byte costs a single update of the marker state machine. Each
// byte passes through the input register; a result shows up on result_o the
// cycle after its byte leaves that register.
// rst_ni (async, active low) returns the scanner to expect the leading 0xFF.
// The output register holds one result; while it waits, bytes that cause no
// result keep flowing, and a byte that would cause one holds in the input register until the result is transferred.
//
module jpeg_frame_header_scanner_top
  import jfhs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  jfhs_byte_if.sink    byte_in_i,
  jfhs_result_if.source result_o
);

  // Input register
  logic       stg_valid_q, stg_valid_d;
  logic [7:0] stg_byte_q;
  logic       stg_last_q;

  // Output register
  logic        out_valid_q, out_valid_d;
  status_e     out_status_q;
  logic [15:0] out_width_q;
  logic [15:0] out_height_q;

  result_t res;
  logic    adv;     // input register byte consumed by the scanner this cycle
  logic    in_xfer;

  jfhs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .data_byte_i (stg_byte_q),
    .last_byte_i (stg_last_q),
    .res_o       (res)
  );

  // A byte may advance unless it produces a result and the output slot is busy
  assign adv = stg_valid_q && (!res.valid || !out_valid_q || result_o.ready);

  assign byte_in_i.ready = !stg_valid_q || adv;
  assign in_xfer         = byte_in_i.valid && byte_in_i.ready;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (in_xfer) begin
      stg_valid_d = 1'b1;
    end else if (adv) begin
      stg_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (adv && res.valid) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stg_byte_q <= byte_in_i.data_byte;
      stg_last_q <= byte_in_i.last_byte;
    end
    if (adv && res.valid) begin
      out_status_q <= res.status;
      out_width_q  <= res.width;
      out_height_q <= res.height;
    end
  end

  assign result_o.valid  = out_valid_q;
  assign result_o.status = out_status_q;
  assign result_o.width  = out_width_q;
  assign result_o.height = out_height_q;

endmodule
